@@ rtl/llcp_pkg.sv @@
package llcp_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS = 16;
	localparam int LIM_W = 31;
	localparam int MUL_DIGIT = 16;
	localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(1);

endpackage

@@ rtl/llcp_mul.sv @@
// Signed multiplier, one DIG-bit digit of b per stage.
module llcp_mul import llcp_pkg::*; #(
	parameter int AW = 33,
	parameter int BW = 33,
	parameter int DIG = MUL_DIGIT
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [AW-1:0]    a,
	input  logic signed [BW-1:0]    b,
	output logic signed [AW+BW-1:0] p
);

	localparam int ND = (BW + DIG - 1) / DIG;
	localparam int BXW = ND * DIG;
	localparam int PW = AW + BW;

	logic signed [AW-1:0]  a_s   [ND];
	logic signed [BXW-1:0] b_s   [ND];
	logic signed [PW-1:0]  acc_s [ND];
	logic signed [BXW-1:0] b_ext;

	assign b_ext = BXW'(b);

	for (genvar i = 0; i < ND; i++) begin : g_stage
		logic signed [AW-1:0]    a_in;
		logic signed [BXW-1:0]   b_in;
		logic signed [PW-1:0]    acc_in;
		logic signed [DIG:0]     dg;
		logic signed [AW+DIG:0]  part;

		if (i == 0) begin : g_first
			assign a_in = a;
			assign b_in = b_ext;
			assign acc_in = '0;
		end else begin : g_next
			assign a_in = a_s[i-1];
			assign b_in = b_s[i-1];
			assign acc_in = acc_s[i-1];
		end

		// top digit carries the sign, the others are plain magnitudes
		if (i == ND - 1) begin : g_top
			assign dg = {b_in[BXW-1], b_in[i*DIG +: DIG]};
		end else begin : g_low
			assign dg = {1'b0, b_in[i*DIG +: DIG]};
		end

		assign part = a_in * dg;

		always_ff @(posedge clk) begin
			if (en) begin
				a_s[i] <= a_in;
				b_s[i] <= b_in;
				acc_s[i] <= acc_in + (PW'(part) <<< (i * DIG));
			end
		end
	end

	assign p = acc_s[ND-1];

endmodule

@@ rtl/llcp_div.sv @@
// Restoring signed divider, den > 0, truncating, saturated to QW bits.
// One quotient bit per stage.
module llcp_div #(
	parameter int NW = 64,
	parameter int DW = 32,
	parameter int QW = 32
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [NW-1:0] num,
	input  logic [DW-1:0]        den,
	output logic signed [QW-1:0] quo
);

	localparam int IW = ((NW > DW + QW) ? NW : DW + QW) + 1;

	logic [IW-1:0]   mag_s [QW];
	logic [QW-2:0]   q_s   [QW];
	logic            neg_s [QW];
	logic            sat_s [QW];
	logic [DW-1:0]   den_s [QW];
	logic [NW-1:0]   num_mag;
	logic [QW-1:0]   qz;

	assign num_mag = num[NW-1] ? NW'(-num) : NW'(num);

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s[0] <= num[NW-1];
			mag_s[0] <= IW'(num_mag);
			den_s[0] <= den;
			q_s[0] <= '0;
		end
	end

	for (genvar j = 1; j < QW; j++) begin : g_step
		localparam int K = QW - 1 - j;
		logic [IW-1:0] dk;
		logic          ge;
		logic          sat_next;

		assign dk = IW'(den_s[j-1]) << K;
		assign ge = mag_s[j-1] >= dk;

		// overflow check rides along with the first step
		if (j == 1) begin : g_sat
			assign sat_next = mag_s[0] >= (IW'(den_s[0]) << (QW - 1));
		end else begin : g_hold
			assign sat_next = sat_s[j-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				mag_s[j] <= ge ? mag_s[j-1] - dk : mag_s[j-1];
				q_s[j] <= q_s[j-1] | ((QW-1)'(ge) << K);
				neg_s[j] <= neg_s[j-1];
				sat_s[j] <= sat_next;
				den_s[j] <= den_s[j-1];
			end
		end
	end

	assign qz = {1'b0, q_s[QW-1]};

	always_ff @(posedge clk) begin
		if (en) begin
			if (sat_s[QW-1]) begin
				quo <= neg_s[QW-1] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
			end else begin
				quo <= neg_s[QW-1] ? QW'(-qz) : qz;
			end
		end
	end

endmodule

@@ rtl/line_line_closest_point_3d.sv @@
// Closest approach of two 3D lines given as segment endpoints, signed fixed
// point with 16 fraction bits.
// Input channel: in_valid / in_stall with twelve coordinate ports. Output
// channel: out_valid / out_stall with found, first_param, second_param and
// the midpoint. A rejected pair (short direction or near-parallel) gives
// found = 0 and all other fields zero.
// cfg_wr_en / cfg_wr_data write near_zero_limit; write only while idle.
// Throughput: one word per cycle while out_stall does not hold the
// pipeline. The five quotient dividers, one bit per stage, make up most of
// the pipeline depth.
// Reset clears all valid bits and loads near_zero_limit with 1.
// While out_valid is high and out_stall is high the whole pipeline holds and
// in_stall is raised; nothing in flight is dropped or repeated.
module line_line_closest_point_3d import llcp_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [LIM_W-1:0]              cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] first_start_x,
	input  logic signed [COORD_WIDTH-1:0] first_start_y,
	input  logic signed [COORD_WIDTH-1:0] first_start_z,
	input  logic signed [COORD_WIDTH-1:0] first_end_x,
	input  logic signed [COORD_WIDTH-1:0] first_end_y,
	input  logic signed [COORD_WIDTH-1:0] first_end_z,
	input  logic signed [COORD_WIDTH-1:0] second_start_x,
	input  logic signed [COORD_WIDTH-1:0] second_start_y,
	input  logic signed [COORD_WIDTH-1:0] second_start_z,
	input  logic signed [COORD_WIDTH-1:0] second_end_x,
	input  logic signed [COORD_WIDTH-1:0] second_end_y,
	input  logic signed [COORD_WIDTH-1:0] second_end_z,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          found,
	output logic signed [COORD_WIDTH-1:0] first_param,
	output logic signed [COORD_WIDTH-1:0] second_param,
	output logic signed [COORD_WIDTH-1:0] mid_x,
	output logic signed [COORD_WIDTH-1:0] mid_y,
	output logic signed [COORD_WIDTH-1:0] mid_z
);

	localparam int W = COORD_WIDTH;
	localparam int AW1 = W + 1;
	localparam int DOTW = 2 * W + 4;
	localparam int NDW = 4 * W + 9;
	localparam int MW = 5 * W + 12;
	localparam int SNW = NDW + FRAC_BITS;
	localparam int LM1 = (AW1 + MUL_DIGIT - 1) / MUL_DIGIT;
	localparam int LM2 = (DOTW + MUL_DIGIT - 1) / MUL_DIGIT;
	localparam int LM3 = (NDW + MUL_DIGIT - 1) / MUL_DIGIT;
	localparam int LD = W + 1;
	localparam int T_DEN = 1 + LM1 + 1 + LM2 + 1;
	localparam int T_MN = T_DEN + LM3 + 1;
	localparam int T_DM = T_MN + LD;
	localparam int T_OUT = T_DM + 1;
	localparam int GEO_D = T_DEN - 1;
	localparam int LAG_D = LM3 + 1;
	localparam int OK_D = T_DM - T_DEN;
	localparam int SW = (AW1 > LIM_W) ? AW1 : LIM_W;
	localparam int TW2 = (NDW > LIM_W + 3 * FRAC_BITS) ? NDW : LIM_W + 3 * FRAC_BITS;

	logic                 en;
	logic [LIM_W-1:0]     lim_q;
	logic                 vld_s [T_OUT];

	logic signed [W-1:0]   p1 [3];
	logic signed [W-1:0]   e1 [3];
	logic signed [W-1:0]   p2 [3];
	logic signed [W-1:0]   e2 [3];

	logic signed [AW1-1:0] a_s1  [3];
	logic signed [AW1-1:0] b_s1  [3];
	logic signed [AW1-1:0] w_s1  [3];
	logic signed [AW1-1:0] ps_s1 [3];
	logic [AW1-1:0]        mag_a [3];
	logic [AW1-1:0]        mag_b [3];
	logic                  small_a;
	logic                  small_b;

	logic signed [AW1-1:0] a_dly  [GEO_D][3];
	logic signed [AW1-1:0] b_dly  [GEO_D][3];
	logic signed [AW1-1:0] ps_dly [GEO_D][3];
	logic                  sm_dly [GEO_D];

	logic signed [2*AW1-1:0] p_aa [3];
	logic signed [2*AW1-1:0] p_bb [3];
	logic signed [2*AW1-1:0] p_ab [3];
	logic signed [2*AW1-1:0] p_wa [3];
	logic signed [2*AW1-1:0] p_wb [3];

	logic signed [DOTW-1:0] dot_aa_s;
	logic signed [DOTW-1:0] dot_bb_s;
	logic signed [DOTW-1:0] dot_ab_s;
	logic signed [DOTW-1:0] dot_wa_s;
	logic signed [DOTW-1:0] dot_wb_s;

	logic signed [2*DOTW-1:0] p_aabb;
	logic signed [2*DOTW-1:0] p_abab;
	logic signed [2*DOTW-1:0] p_wbab;
	logic signed [2*DOTW-1:0] p_wabb;
	logic signed [2*DOTW-1:0] p_aawb;
	logic signed [2*DOTW-1:0] p_abwa;

	logic signed [NDW-1:0] den_sd;
	logic signed [NDW-1:0] nu_sd;
	logic signed [NDW-1:0] tn_sd;
	logic                  ok_next;
	logic                  ok_dly [OK_D];
	logic signed [NDW-1:0] den_dly [LAG_D];

	logic signed [AW1+NDW-1:0] p_pd [3];
	logic signed [AW1+NDW-1:0] p_an [3];
	logic signed [AW1+NDW-1:0] p_bt [3];
	logic signed [MW-1:0]      mnum_s [3];

	logic signed [W-1:0] s_quo;
	logic signed [W-1:0] t_quo;
	logic signed [W-1:0] s_dly [LAG_D];
	logic signed [W-1:0] t_dly [LAG_D];
	logic signed [W-1:0] m_quo [3];

	logic                found_q;
	logic signed [W-1:0] first_param_q;
	logic signed [W-1:0] second_param_q;
	logic signed [W-1:0] mid_q [3];

	// advance everything unless a finished word is held at the output
	assign en = !(vld_s[T_OUT-1] && out_stall);
	assign in_stall = !en;

	assign p1[0] = first_start_x;
	assign p1[1] = first_start_y;
	assign p1[2] = first_start_z;
	assign e1[0] = first_end_x;
	assign e1[1] = first_end_y;
	assign e1[2] = first_end_z;
	assign p2[0] = second_start_x;
	assign p2[1] = second_start_y;
	assign p2[2] = second_start_z;
	assign e2[0] = second_end_x;
	assign e2[1] = second_end_y;
	assign e2[2] = second_end_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= LIM_RESET;
		end else if (cfg_wr_en) begin
			lim_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < T_OUT; i++) vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int i = 1; i < T_OUT; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	// directions, offset and start sum
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				a_s1[c] <= AW1'(e1[c]) - AW1'(p1[c]);
				b_s1[c] <= AW1'(e2[c]) - AW1'(p2[c]);
				w_s1[c] <= AW1'(p1[c]) - AW1'(p2[c]);
				ps_s1[c] <= AW1'(p1[c]) + AW1'(p2[c]);
			end
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_mag
		assign mag_a[c] = a_s1[c][AW1-1] ? AW1'(-a_s1[c]) : AW1'(a_s1[c]);
		assign mag_b[c] = b_s1[c][AW1-1] ? AW1'(-b_s1[c]) : AW1'(b_s1[c]);
	end

	always_comb begin
		small_a = 1'b1;
		small_b = 1'b1;
		for (int c = 0; c < 3; c++) begin
			if (SW'(mag_a[c]) >= SW'(lim_q)) small_a = 1'b0;
			if (SW'(mag_b[c]) >= SW'(lim_q)) small_b = 1'b0;
		end
	end

	// carry geometry and the short-direction flag down to the denominator stage
	always_ff @(posedge clk) begin
		if (en) begin
			sm_dly[0] <= small_a || small_b;
			for (int c = 0; c < 3; c++) begin
				a_dly[0][c] <= a_s1[c];
				b_dly[0][c] <= b_s1[c];
				ps_dly[0][c] <= ps_s1[c];
			end
			for (int i = 1; i < GEO_D; i++) begin
				sm_dly[i] <= sm_dly[i-1];
				for (int c = 0; c < 3; c++) begin
					a_dly[i][c] <= a_dly[i-1][c];
					b_dly[i][c] <= b_dly[i-1][c];
					ps_dly[i][c] <= ps_dly[i-1][c];
				end
			end
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_mul1
		llcp_mul #(.AW(AW1), .BW(AW1)) u_aa (
			.clk(clk), .en(en), .a(a_s1[c]), .b(a_s1[c]), .p(p_aa[c]));
		llcp_mul #(.AW(AW1), .BW(AW1)) u_bb (
			.clk(clk), .en(en), .a(b_s1[c]), .b(b_s1[c]), .p(p_bb[c]));
		llcp_mul #(.AW(AW1), .BW(AW1)) u_ab (
			.clk(clk), .en(en), .a(a_s1[c]), .b(b_s1[c]), .p(p_ab[c]));
		llcp_mul #(.AW(AW1), .BW(AW1)) u_wa (
			.clk(clk), .en(en), .a(w_s1[c]), .b(a_s1[c]), .p(p_wa[c]));
		llcp_mul #(.AW(AW1), .BW(AW1)) u_wb (
			.clk(clk), .en(en), .a(w_s1[c]), .b(b_s1[c]), .p(p_wb[c]));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dot_aa_s <= DOTW'(p_aa[0]) + DOTW'(p_aa[1]) + DOTW'(p_aa[2]);
			dot_bb_s <= DOTW'(p_bb[0]) + DOTW'(p_bb[1]) + DOTW'(p_bb[2]);
			dot_ab_s <= DOTW'(p_ab[0]) + DOTW'(p_ab[1]) + DOTW'(p_ab[2]);
			dot_wa_s <= DOTW'(p_wa[0]) + DOTW'(p_wa[1]) + DOTW'(p_wa[2]);
			dot_wb_s <= DOTW'(p_wb[0]) + DOTW'(p_wb[1]) + DOTW'(p_wb[2]);
		end
	end

	llcp_mul #(.AW(DOTW), .BW(DOTW)) u_aabb (
		.clk(clk), .en(en), .a(dot_aa_s), .b(dot_bb_s), .p(p_aabb));
	llcp_mul #(.AW(DOTW), .BW(DOTW)) u_abab (
		.clk(clk), .en(en), .a(dot_ab_s), .b(dot_ab_s), .p(p_abab));
	llcp_mul #(.AW(DOTW), .BW(DOTW)) u_wbab (
		.clk(clk), .en(en), .a(dot_wb_s), .b(dot_ab_s), .p(p_wbab));
	llcp_mul #(.AW(DOTW), .BW(DOTW)) u_wabb (
		.clk(clk), .en(en), .a(dot_wa_s), .b(dot_bb_s), .p(p_wabb));
	llcp_mul #(.AW(DOTW), .BW(DOTW)) u_aawb (
		.clk(clk), .en(en), .a(dot_aa_s), .b(dot_wb_s), .p(p_aawb));
	llcp_mul #(.AW(DOTW), .BW(DOTW)) u_abwa (
		.clk(clk), .en(en), .a(dot_ab_s), .b(dot_wa_s), .p(p_abwa));

	always_ff @(posedge clk) begin
		if (en) begin
			den_sd <= NDW'(p_aabb) - NDW'(p_abab);
			nu_sd <= NDW'(p_wbab) - NDW'(p_wabb);
			tn_sd <= NDW'(p_aawb) - NDW'(p_abwa);
		end
	end

	// the denominator is never negative; compare it against limit * 2^48
	assign ok_next = !sm_dly[GEO_D-1] && (den_sd != '0) &&
		($unsigned(TW2'(den_sd)) >= (TW2'(lim_q) << (3 * FRAC_BITS)));

	always_ff @(posedge clk) begin
		if (en) begin
			ok_dly[0] <= ok_next;
			for (int i = 1; i < OK_D; i++) ok_dly[i] <= ok_dly[i-1];
			den_dly[0] <= den_sd;
			s_dly[0] <= s_quo;
			t_dly[0] <= t_quo;
			for (int i = 1; i < LAG_D; i++) begin
				den_dly[i] <= den_dly[i-1];
				s_dly[i] <= s_dly[i-1];
				t_dly[i] <= t_dly[i-1];
			end
		end
	end

	llcp_div #(.NW(SNW), .DW(NDW), .QW(W)) u_div_s (
		.clk(clk), .en(en), .num(SNW'(nu_sd) <<< FRAC_BITS),
		.den($unsigned(den_sd)), .quo(s_quo));
	llcp_div #(.NW(SNW), .DW(NDW), .QW(W)) u_div_t (
		.clk(clk), .en(en), .num(SNW'(tn_sd) <<< FRAC_BITS),
		.den($unsigned(den_sd)), .quo(t_quo));

	for (genvar c = 0; c < 3; c++) begin : g_mid
		llcp_mul #(.AW(AW1), .BW(NDW)) u_pd (
			.clk(clk), .en(en), .a(ps_dly[GEO_D-1][c]), .b(den_sd), .p(p_pd[c]));
		llcp_mul #(.AW(AW1), .BW(NDW)) u_an (
			.clk(clk), .en(en), .a(a_dly[GEO_D-1][c]), .b(nu_sd), .p(p_an[c]));
		llcp_mul #(.AW(AW1), .BW(NDW)) u_bt (
			.clk(clk), .en(en), .a(b_dly[GEO_D-1][c]), .b(tn_sd), .p(p_bt[c]));

		always_ff @(posedge clk) begin
			if (en) begin
				mnum_s[c] <= MW'(p_pd[c]) + MW'(p_an[c]) + MW'(p_bt[c]);
			end
		end

		// divide by twice the denominator
		llcp_div #(.NW(MW), .DW(NDW + 1), .QW(W)) u_div_m (
			.clk(clk), .en(en), .num(mnum_s[c]),
			.den({den_dly[LAG_D-1], 1'b0}), .quo(m_quo[c]));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			found_q <= ok_dly[OK_D-1];
			first_param_q <= ok_dly[OK_D-1] ? s_dly[LAG_D-1] : '0;
			second_param_q <= ok_dly[OK_D-1] ? t_dly[LAG_D-1] : '0;
			for (int c = 0; c < 3; c++) begin
				mid_q[c] <= ok_dly[OK_D-1] ? m_quo[c] : '0;
			end
		end
	end

	assign out_valid = vld_s[T_OUT-1];
	assign found = found_q;
	assign first_param = first_param_q;
	assign second_param = second_param_q;
	assign mid_x = mid_q[0];
	assign mid_y = mid_q[1];
	assign mid_z = mid_q[2];

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> first_param == '0 && second_param == '0 &&
			mid_x == '0 && mid_y == '0 && mid_z == '0)
		else $error("rejected word carries nonzero fields");

	a_accept_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with an empty output register");

	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(vld_s[T_OUT-2]))
		else $error("output word appeared without a word in the last stage");

endmodule

@@ verif/testbench.sv @@
module testbench import llcp_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = COORD_WIDTH_DEF;
	localparam int LATENCY = 55;
	localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic signed [CW-1:0] ONE = CW'(65536);

	typedef logic signed [255:0] big_t;

	// coordinate order: first start xyz, first end xyz, second start xyz, second end xyz
	typedef struct {
		logic signed [CW-1:0] c [12];
	} seg_pair_t;

	typedef struct {
		logic                 found;
		logic signed [CW-1:0] s_par;
		logic signed [CW-1:0] t_par;
		logic signed [CW-1:0] mid [3];
	} approach_t;

	typedef struct {
		seg_pair_t pair;
		bit        typed;
		approach_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [LIM_W-1:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [CW-1:0] coord [12];
	logic out_valid;
	logic out_stall = 1'b0;
	logic found;
	logic signed [CW-1:0] first_param, second_param, mid_x, mid_y, mid_z;

	logic [LIM_W-1:0] limit_now = LIM_RESET;
	approach_t expected_q [$];
	int bad_cnt = 0;
	bit calm = 1'b0;

	initial for (int i = 0; i < 12; i++) coord[i] = '0;

	always #2 clk = ~clk;

	line_line_closest_point_3d #(.COORD_WIDTH(CW)) u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.first_start_x(coord[0]), .first_start_y(coord[1]), .first_start_z(coord[2]),
		.first_end_x(coord[3]), .first_end_y(coord[4]), .first_end_z(coord[5]),
		.second_start_x(coord[6]), .second_start_y(coord[7]), .second_start_z(coord[8]),
		.second_end_x(coord[9]), .second_end_y(coord[10]), .second_end_z(coord[11]),
		.out_valid(out_valid), .out_stall(out_stall), .found(found),
		.first_param(first_param), .second_param(second_param),
		.mid_x(mid_x), .mid_y(mid_y), .mid_z(mid_z)
	);

	function automatic logic signed [CW-1:0] quot_sat(big_t num, big_t den);
		big_t q;
		q = num / den;
		if (q > big_t'(C_MAX)) return C_MAX;
		if (q < big_t'(C_MIN)) return C_MIN;
		return q[CW-1:0];
	endfunction

	function automatic big_t dot3(big_t x [3], big_t y [3]);
		return x[0] * y[0] + x[1] * y[1] + x[2] * y[2];
	endfunction

	function automatic bit all_below(big_t v [3], big_t thr);
		for (int i = 0; i < 3; i++)
			if ((v[i] < 0 ? -v[i] : v[i]) >= thr) return 1'b0;
		return 1'b1;
	endfunction

	function automatic approach_t closest_approach(seg_pair_t p, logic [LIM_W-1:0] lim);
		approach_t r;
		big_t s1 [3], s2 [3], a [3], b [3], w [3];
		big_t thr, aa, bb, ab, wa, wb, den, nu, tn, x;
		r.found = 1'b0;
		r.s_par = '0;
		r.t_par = '0;
		for (int i = 0; i < 3; i++) begin
			r.mid[i] = '0;
			s1[i] = big_t'(p.c[i]);
			s2[i] = big_t'(p.c[6+i]);
			a[i] = big_t'(p.c[3+i]) - s1[i];
			b[i] = big_t'(p.c[9+i]) - s2[i];
			w[i] = s1[i] - s2[i];
		end
		thr = big_t'({1'b0, lim});
		if (all_below(b, thr) || all_below(a, thr)) return r;
		aa = dot3(a, a);
		bb = dot3(b, b);
		ab = dot3(a, b);
		wa = dot3(w, a);
		wb = dot3(w, b);
		den = aa * bb - ab * ab;
		if (den == 0 || den < (thr <<< 48)) return r;
		nu = wb * ab - wa * bb;
		tn = aa * wb - ab * wa;
		r.found = 1'b1;
		r.s_par = quot_sat(nu <<< 16, den);
		r.t_par = quot_sat(tn <<< 16, den);
		for (int i = 0; i < 3; i++) begin
			x = (s1[i] + s2[i]) * den + a[i] * nu + b[i] * tn;
			r.mid[i] = quot_sat(x, den <<< 1);
		end
		return r;
	endfunction

	// check each accepted result word against the oldest prediction
	always @(posedge clk) begin
		approach_t e;
		if (out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				bad_cnt++;
				if (bad_cnt <= 10) $display("unexpected result word found=%0d", found);
			end else begin
				e = expected_q.pop_front();
				if (found !== e.found || first_param !== e.s_par || second_param !== e.t_par ||
						mid_x !== e.mid[0] || mid_y !== e.mid[1] || mid_z !== e.mid[2]) begin
					bad_cnt++;
					if (bad_cnt <= 10)
						$display("bad word: want %0d %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d %0d",
							e.found, e.s_par, e.t_par, e.mid[0], e.mid[1], e.mid[2],
							found, first_param, second_param, mid_x, mid_y, mid_z);
				end
			end
		end
	end

	always @(negedge clk)
		if (arst_n) out_stall <= !calm && ($urandom_range(99) < 10);

	task automatic send_pair(seg_pair_t p, bit typed, approach_t want);
		while (!calm && $urandom_range(99) < 10) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		for (int i = 0; i < 12; i++) coord[i] <= p.c[i];
		do @(posedge clk); while (in_stall);
		expected_q.push_back(typed ? want : closest_approach(p, limit_now));
		@(negedge clk);
	endtask

	task automatic set_limit(logic [LIM_W-1:0] v);
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		limit_now = v;
		@(negedge clk);
	endtask

	function automatic logic signed [CW-1:0] small_val();
		return CW'(signed'($urandom_range(0, 1 << 21)) - (1 << 20));
	endfunction

	function automatic seg_pair_t random_pair();
		seg_pair_t p;
		int mode;
		mode = $urandom_range(9);
		for (int i = 0; i < 12; i++)
			p.c[i] = (mode == 5 || mode == 6) ? CW'($urandom) : small_val();
		if (mode == 7) begin
			// near-parallel: second direction tracks the first
			for (int i = 0; i < 3; i++)
				p.c[9+i] = p.c[6+i] + (p.c[3+i] - p.c[i]) + CW'($urandom_range(0, 3));
		end else if (mode == 8) begin
			// short direction near the limit
			for (int i = 0; i < 3; i++)
				p.c[3+i] = p.c[i] + CW'($urandom_range(0, 4)) - 2;
		end
		return p;
	endfunction

	initial begin
		row_t rows [8];
		approach_t none, perp;
		seg_pair_t zp;
		none.found = 1'b0;
		none.s_par = '0;
		none.t_par = '0;
		for (int i = 0; i < 3; i++) none.mid[i] = '0;
		perp = none;
		perp.found = 1'b1;
		perp.mid[2] = CW'(32768);
		for (int i = 0; i < 12; i++) zp.c[i] = '0;
		foreach (rows[r]) begin
			rows[r].pair = zp;
			rows[r].typed = 1'b0;
			rows[r].want = none;
		end
		rows[0].typed = 1'b1;
		// x axis against y axis lifted by one: closest points meet at z = 0.5
		rows[1].pair.c[3] = ONE;
		rows[1].pair.c[8] = ONE;
		rows[1].pair.c[10] = ONE;
		rows[1].pair.c[11] = ONE;
		rows[1].typed = 1'b1;
		rows[1].want = perp;
		// parallel x lines
		rows[2].pair.c[3] = ONE;
		rows[2].pair.c[7] = ONE;
		rows[2].pair.c[9] = ONE;
		rows[2].pair.c[10] = ONE;
		rows[2].typed = 1'b1;
		// first direction zero
		rows[3].pair.c[9] = ONE;
		rows[3].typed = 1'b1;
		for (int i = 0; i < 12; i++) begin
			rows[4].pair.c[i] = (i % 2) ? C_MAX : C_MIN;
			rows[5].pair.c[i] = (i % 3) ? C_MIN : C_MAX;
			rows[6].pair.c[i] = ((i / 3) % 2) ? C_MAX : C_MIN;
			rows[7].pair.c[i] = (i % 4 == 1) ? ONE : (i % 5 == 0 ? C_MAX : -ONE);
		end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (rows[r]) send_pair(rows[r].pair, rows[r].typed, rows[r].want);
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				1: set_limit('0);
				2: set_limit({LIM_W{1'b1}});
				3: set_limit(LIM_W'($urandom_range(0, 1 << 18)));
				4: set_limit(LIM_W'(1));
				default: ;
			endcase
			for (int n = 0; n < 110; n++) begin
				calm = (ph == 3 && n >= 30 && n < 90);
				send_pair(random_pair(), 1'b0, none);
			end
			calm = 1'b0;
		end
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (bad_cnt == 0)
			$display("line_line_closest_point_3d: match");
		else
			$display("line_line_closest_point_3d: mismatch");
		$finish;
	end

	initial begin
		#2000000;
		$display("line_line_closest_point_3d: mismatch");
		$finish;
	end

endmodule
